// ===== hdl/ppsch_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsch_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package ppsch_pkg;

  localparam int unsigned ArrW  = 16;
  localparam int unsigned BurW  = 16;
  localparam int unsigned PriW  = 8;
  localparam int unsigned IdW   = 5;
  localparam int unsigned TimeW = 21;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic ActAdd  = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusZero = 2'd2;

  typedef struct packed {
    logic            action;
    logic [ArrW-1:0] arrive_tick;
    logic [BurW-1:0] service_len;
    logic [PriW-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   assigned_id;
    logic             ran_valid;
    logic [IdW-1:0]   ran_id;
    logic             finished;
    logic [TimeW-1:0] complete_tick;
    logic [TimeW-1:0] turnaround_len;
    logic [TimeW-1:0] wait_len;
    logic             all_done;
    logic [TimeW-1:0] time_now;
  } out_item_t;

  // Best candidate travelling down the cell row.
  typedef struct packed {
    logic            found;
    logic [PriW-1:0] prio;
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [BurW-1:0] remaining;
  } cand_t;

  // Write command broadcast to the cells.
  typedef struct packed {
    logic            add;
    logic            upd;
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [PriW-1:0] prio;
    logic [BurW-1:0] remaining;
    logic            done;
  } cell_wr_t;

endpackage

// ===== hdl/ppsch_cell.sv =====
// ----------------------------------------------------------------------------
// ppsch_cell
// One process slot; merges its process into the passing best candidate.
// ----------------------------------------------------------------------------
module ppsch_cell #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  localparam int unsigned CntW = $clog2(MAX_PROCESSES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [CntW-1:0]                count_i,
  input  logic [ppsch_pkg::TimeW-1:0]    time_i,
  input  ppsch_pkg::cell_wr_t            wr_i,
  input  logic [IdxW-1:0]                wr_slot_i,
  input  ppsch_pkg::cand_t               cand_i,
  input  logic [IdxW-1:0]                slot_i,
  output ppsch_pkg::cand_t               cand_o,
  output logic [IdxW-1:0]                slot_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(CELL_IDX);

  logic [ppsch_pkg::ArrW-1:0] arr_q;
  logic [ppsch_pkg::BurW-1:0] bur_q;
  logic [ppsch_pkg::BurW-1:0] rem_q;
  logic [ppsch_pkg::PriW-1:0] pri_q;
  logic                       done_q;

  ppsch_pkg::cand_t  cand_q, cand_d;
  logic [IdxW-1:0]   slot_q, slot_d;

  logic loaded, eligible, take, hit;

  assign hit      = (wr_slot_i == MyIdx);
  assign loaded   = (MyCnt < count_i);
  assign eligible = loaded && !done_q &&
                    ({{(ppsch_pkg::TimeW - ppsch_pkg::ArrW){1'b0}}, arr_q} <= time_i);
  assign take     = eligible && (!cand_i.found || (pri_q < cand_i.prio));

  always_comb begin
    cand_d = cand_i;
    slot_d = slot_i;
    if (take) begin
      cand_d.found     = 1'b1;
      cand_d.prio      = pri_q;
      cand_d.arrival   = arr_q;
      cand_d.burst     = bur_q;
      cand_d.remaining = rem_q;
      slot_d           = MyIdx;
    end
  end

  // Slot contents: written on add, remaining/done updated after a run.
  always_ff @(posedge clk_i) begin
    if (wr_i.add && hit) begin
      arr_q  <= wr_i.arrival;
      bur_q  <= wr_i.burst;
      rem_q  <= wr_i.burst;
      pri_q  <= wr_i.prio;
      done_q <= 1'b0;
    end else if (wr_i.upd && hit) begin
      rem_q  <= wr_i.remaining;
      done_q <= wr_i.done;
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      slot_q <= '0;
    end else begin
      cand_q <= cand_d;
      slot_q <= slot_d;
    end
  end

  assign cand_o = cand_q;
  assign slot_o = slot_q;

endmodule

// ===== hdl/priority_preemptive_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler
// Preemptive priority scheduler built as a row of process-slot cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// item; action 0 adds a process, action 1 advances time by one tick.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result
// transaction per input transaction, in order.
// An add goes from acceptance to the result state; a tick first lets the
// best-candidate wave walk the cell row one slot per cycle, then passes the
// run update, turnaround and waiting time states before the result state,
// which loads the output register and holds while that register is busy.
// One item is in flight at a time and in_stall_o is low only while the
// controller is idle, so no new item is taken before the result is loaded.
// The result sits in an output register: a new input transaction is taken
// while the receiver stalls the previous result, and a finished result
// waits in the controller until that register frees up.
// Reset clears the process count, unfinished count, time and output valid;
// slot contents are not cleared, only slots below the process count are read.
// ----------------------------------------------------------------------------
module priority_preemptive_scheduler #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ppsch_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ppsch_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TW   = ppsch_pkg::TimeW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_TAT,
    S_WT,
    S_RESP
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        unfin_q;
  logic [TW-1:0]          clock_q;
  logic [IdxW-1:0]        scan_q;
  ppsch_pkg::out_item_t   res_q, res_d;
  ppsch_pkg::out_item_t   resp;
  ppsch_pkg::out_item_t   out_q;
  logic                   out_valid_q;
  logic [ppsch_pkg::ArrW-1:0] best_arr_q;
  logic [ppsch_pkg::BurW-1:0] best_bur_q;

  // Candidate chain: index 0 is the empty wave head, the last is the winner.
  ppsch_pkg::cand_t       cand_s [MAX_PROCESSES+1];
  logic [IdxW-1:0]        slot_s [MAX_PROCESSES+1];

  ppsch_pkg::cell_wr_t    wr;
  logic [IdxW-1:0]        wr_slot;

  logic                   accept, full, add_ok, out_free;
  ppsch_pkg::cand_t       best;
  logic [IdxW-1:0]        best_slot;
  logic [ppsch_pkg::BurW-1:0] new_rem;
  logic                   fin;
  logic [TW-1:0]          clock_inc;
  logic [IdxW:0]          add_id_full, ran_id_full;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign full      = (count_q == CntW'(MAX_PROCESSES));
  assign add_ok    = !full && (in_data_i.service_len != '0);

  assign best      = cand_s[MAX_PROCESSES];
  assign best_slot = slot_s[MAX_PROCESSES];
  assign new_rem   = (best.remaining != '0) ? best.remaining - 1'b1 : '0;
  assign fin       = (new_rem == '0);
  assign clock_inc = (clock_q != ppsch_pkg::TimeMax) ? clock_q + 1'b1 : clock_q;

  assign add_id_full = {1'b0, count_q[IdxW-1:0]} + 1'b1;
  assign ran_id_full = {1'b0, best_slot} + 1'b1;

  // Cell write command: add on acceptance, run update in the evaluate step.
  always_comb begin
    wr           = '0;
    wr.add       = accept && (in_data_i.action == ppsch_pkg::ActAdd) && add_ok;
    wr.upd       = (state_q == S_EVAL) && best.found;
    wr.arrival   = in_data_i.arrive_tick;
    wr.burst     = in_data_i.service_len;
    wr.prio      = in_data_i.priority_req;
    wr.remaining = new_rem;
    wr.done      = fin;
    wr_slot      = (state_q == S_EVAL) ? best_slot : count_q[IdxW-1:0];
  end

  // Build the result step by step: status on acceptance, run report in the
  // evaluate step, then turnaround and waiting time.
  always_comb begin
    res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          if (in_data_i.action == ppsch_pkg::ActAdd) begin
            if (full) begin
              res_d.status = ppsch_pkg::StatusFull;
            end else if (!add_ok) begin
              res_d.status = ppsch_pkg::StatusZero;
            end else begin
              res_d.status      = ppsch_pkg::StatusOk;
              res_d.assigned_id = ppsch_pkg::IdW'(add_id_full);
            end
          end
        end
      end
      S_EVAL: begin
        if (best.found) begin
          res_d.ran_valid = 1'b1;
          res_d.ran_id    = ppsch_pkg::IdW'(ran_id_full);
          if (fin) begin
            res_d.finished      = 1'b1;
            res_d.complete_tick = clock_inc;
          end
        end
      end
      S_TAT: begin
        if (res_q.finished) begin
          res_d.turnaround_len = res_q.complete_tick -
              {{(TW - ppsch_pkg::ArrW){1'b0}}, best_arr_q};
        end
      end
      S_WT: begin
        // Clamp the waiting time at zero once time has saturated.
        if (res_q.finished &&
            (res_q.turnaround_len >= {{(TW - ppsch_pkg::BurW){1'b0}}, best_bur_q})) begin
          res_d.wait_len = res_q.turnaround_len -
              {{(TW - ppsch_pkg::BurW){1'b0}}, best_bur_q};
        end
      end
      default: begin
      end
    endcase
  end

  // Completed result with the table-wide fields filled in.
  always_comb begin
    resp          = res_q;
    resp.all_done = (unfin_q == '0);
    resp.time_now = clock_q;
  end

  assign cand_s[0] = '0;
  assign slot_s[0] = '0;

  for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
    ppsch_cell #(
      .MAX_PROCESSES(MAX_PROCESSES),
      .CELL_IDX     (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .count_i  (count_q),
      .time_i   (clock_q),
      .wr_i     (wr),
      .wr_slot_i(wr_slot),
      .cand_i   (cand_s[g]),
      .slot_i   (slot_s[g]),
      .cand_o   (cand_s[g+1]),
      .slot_o   (slot_s[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      unfin_q     <= '0;
      clock_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      best_arr_q  <= '0;
      best_bur_q  <= '0;
    end else begin
      res_q <= res_d;
      // Load a finished result when the register is free; otherwise drop
      // the held result once the receiver takes it.
      if ((state_q == S_RESP) && out_free) begin
        out_q       <= resp;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.action == ppsch_pkg::ActAdd) begin
              if (add_ok) begin
                count_q <= count_q + 1'b1;
                unfin_q <= unfin_q + 1'b1;
              end
              state_q <= S_RESP;
            end else begin
              scan_q  <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Wait for the wave to reach the end of the row.
          if (scan_q == IdxW'(MAX_PROCESSES - 1)) begin
            state_q <= S_EVAL;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_EVAL: begin
          clock_q    <= clock_inc;
          best_arr_q <= best.arrival;
          best_bur_q <= best.burst;
          if (best.found && fin) begin
            unfin_q <= unfin_q - 1'b1;
          end
          state_q <= S_TAT;
        end
        S_TAT: begin
          state_q <= S_WT;
        end
        S_WT: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free, then advance.
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Unfinished processes are a subset of the loaded ones.
  a_unfin_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unfin_q <= count_q)
    else $error("unfinished count exceeds process count");

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_PROCESSES))
    else $error("process count beyond capacity");

  // Time never moves backward.
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> clock_q >= $past(clock_q))
    else $error("time decreased");

  // A completion is always reported for a process that ran.
  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.finished |-> out_data_o.ran_valid)
    else $error("finish reported without a run");

endmodule

// ===== sim/priority_preemptive_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler_tb
// Self-checking testbench of the preemptive priority scheduler. A behavioral
// predictor keeps its own process table and clock, computes the report of
// every accepted transaction and compares each returned report field by
// field. Directed scenarios come first, then random traffic under four
// idle/stall profiles.
// ----------------------------------------------------------------------------
module priority_preemptive_scheduler_tb;

  localparam int unsigned MAX_PROCESSES = 16;
  // The drain wait covers a tick's full pass through the scan and result states.
  localparam int unsigned DRAIN_CYCLES  = MAX_PROCESSES + 8;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 320;
  localparam int unsigned TW            = ppsch_pkg::TimeW;
  localparam int unsigned InBits        = $bits(ppsch_pkg::in_item_t);

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  ppsch_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ppsch_pkg::out_item_t out_data_o;

  // Percent chance per cycle that the sender idles / the receiver stalls.
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Predictor copy of the process table and the clock.
  logic [ppsch_pkg::ArrW-1:0] proc_arrival   [MAX_PROCESSES];
  logic [ppsch_pkg::BurW-1:0] proc_burst     [MAX_PROCESSES];
  logic [ppsch_pkg::BurW-1:0] proc_remaining [MAX_PROCESSES];
  logic [ppsch_pkg::PriW-1:0] proc_priority  [MAX_PROCESSES];
  logic                       proc_done      [MAX_PROCESSES];
  int unsigned                slot_count;
  logic [TW-1:0]              sched_time;

  // Reports predicted for accepted transactions, oldest first.
  ppsch_pkg::out_item_t pending_reports[$];

  priority_preemptive_scheduler #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[priority_preemptive_scheduler] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure; one draw per cycle, so stalls land on every phase
  // of the scan and on results held in the output register.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
  end

  // Advance the predicted scheduler by one transaction and return its report.
  function automatic ppsch_pkg::out_item_t compute_schedule_report(
      ppsch_pkg::in_item_t item);
    ppsch_pkg::out_item_t rep;
    logic                 found;
    int unsigned          best;
    int unsigned          tat;
    logic                 all_fin;
    rep   = '0;
    found = 1'b0;
    best  = 0;
    if (item.action == ppsch_pkg::ActAdd) begin
      if (slot_count >= MAX_PROCESSES) begin
        rep.status = ppsch_pkg::StatusFull;
      end else if (item.service_len == '0) begin
        rep.status = ppsch_pkg::StatusZero;
      end else begin
        proc_arrival[slot_count]   = item.arrive_tick;
        proc_burst[slot_count]     = item.service_len;
        proc_remaining[slot_count] = item.service_len;
        proc_priority[slot_count]  = item.priority_req;
        proc_done[slot_count]      = 1'b0;
        slot_count                 = slot_count + 1;
        rep.status                 = ppsch_pkg::StatusOk;
        rep.assigned_id            = ppsch_pkg::IdW'(slot_count);
      end
    end else begin
      // Strict less-than keeps the lowest slot on equal priority.
      for (int unsigned i = 0; i < slot_count; i++) begin
        if (!proc_done[i] && (TW'(proc_arrival[i]) <= sched_time)) begin
          if (!found || (proc_priority[i] < proc_priority[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (sched_time != ppsch_pkg::TimeMax) sched_time = sched_time + 1'b1;
      if (found) begin
        rep.ran_valid = 1'b1;
        rep.ran_id    = ppsch_pkg::IdW'(best + 1);
        if (proc_remaining[best] != '0) proc_remaining[best] = proc_remaining[best] - 1'b1;
        if (proc_remaining[best] == '0) begin
          proc_done[best]    = 1'b1;
          rep.finished       = 1'b1;
          rep.complete_tick  = sched_time;
          tat                = 32'(sched_time) - 32'(proc_arrival[best]);
          rep.turnaround_len = TW'(tat);
          // Clamp at zero once time has saturated.
          rep.wait_len       = (tat >= 32'(proc_burst[best]))
                               ? TW'(tat - 32'(proc_burst[best])) : '0;
        end
      end
    end
    all_fin = 1'b1;
    for (int unsigned i = 0; i < slot_count; i++) begin
      if (!proc_done[i]) all_fin = 1'b0;
    end
    rep.all_done = all_fin;
    rep.time_now = sched_time;
    return rep;
  endfunction

  function automatic void check_field(string name, logic [TW-1:0] want,
                                      logic [TW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted report against the oldest prediction.
  always @(posedge clk_i) begin
    ppsch_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("report arrived with no transaction outstanding");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status",         TW'(want.status),      TW'(out_data_o.status));
        check_field("assigned_id",    TW'(want.assigned_id), TW'(out_data_o.assigned_id));
        check_field("ran_valid",      TW'(want.ran_valid),   TW'(out_data_o.ran_valid));
        check_field("ran_id",         TW'(want.ran_id),      TW'(out_data_o.ran_id));
        check_field("finished",       TW'(want.finished),    TW'(out_data_o.finished));
        check_field("complete_tick",  want.complete_tick,    out_data_o.complete_tick);
        check_field("turnaround_len", want.turnaround_len,   out_data_o.turnaround_len);
        check_field("wait_len",       want.wait_len,         out_data_o.wait_len);
        check_field("all_done",       TW'(want.all_done),    TW'(out_data_o.all_done));
        check_field("time_now",       want.time_now,         out_data_o.time_now);
      end
    end
  end

  // Drive one transaction. Valid stays high from one transaction into the
  // next unless the sender idles, so it is never dropped and raised in the
  // same step.
  task automatic send_item(ppsch_pkg::in_item_t item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pending_reports.push_back(compute_schedule_report(item));
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_add(logic [ppsch_pkg::ArrW-1:0] arr, logic [ppsch_pkg::BurW-1:0] bur,
                          logic [ppsch_pkg::PriW-1:0] pri);
    send_item('{action: ppsch_pkg::ActAdd, arrive_tick: arr, service_len: bur,
                priority_req: pri});
  endtask

  task automatic send_tick();
    ppsch_pkg::in_item_t item;
    // Add fields ride along with random content; the block ignores them.
    item        = ppsch_pkg::in_item_t'(InBits'({$urandom, $urandom}));
    item.action = ppsch_pkg::ActTick;
    send_item(item);
  endtask

  // Idle ticks on an empty table, and a zero-burst add turned away.
  task automatic test_empty_table();
    send_tick();
    send_tick();
    send_add('0, '0, '0);
  endtask

  // Lowest priority value wins, lowest slot breaks ties, and the table
  // drains to all done.
  task automatic test_priority_pick();
    send_add(16'd2, 16'd2, 8'd5);
    send_add(16'd0, 16'd1, 8'd255);
    send_add(16'd0, 16'd1, 8'd5);
    send_add(16'd0, 16'd2, 8'd5);
    repeat (7) send_tick();
  endtask

  // Add after time has moved on; an arrival already past is eligible at once.
  task automatic test_late_add();
    send_add(16'd3, 16'd2, 8'd9);
    send_tick();
    send_tick();
  endtask

  // Widest fields: a process that never arrives within the run keeps
  // all_done low from here on.
  task automatic test_extreme_fields();
    send_add(16'hFFFF, 16'hFFFF, 8'd0);
    send_tick();
  endtask

  // Mostly ticks with sparse adds, some of zero burst, until the table fills; once
  // full, adds carry arbitrary fields and must be rejected as full. Time
  // saturation needs about two million ticks and is beyond this run.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct);
    ppsch_pkg::in_item_t item;
    int unsigned         now16;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      if (slot_count < MAX_PROCESSES && $urandom_range(0, 99) < 3) begin
        now16 = (sched_time > 21'h00FFFF) ? 32'hFFFF : 32'(sched_time);
        item.action       = ppsch_pkg::ActAdd;
        item.arrive_tick  = $urandom_range(0, 1)
                            ? ppsch_pkg::ArrW'($urandom_range(0, now16))
                            : ppsch_pkg::ArrW'((now16 + $urandom_range(0, 20) > 32'hFFFF)
                                               ? 32'hFFFF
                                               : now16 + $urandom_range(0, 20));
        item.service_len  = ($urandom_range(0, 7) == 0)
                            ? '0 : ppsch_pkg::BurW'($urandom_range(1, 100));
        item.priority_req = $urandom_range(0, 3) ? ppsch_pkg::PriW'($urandom_range(0, 7))
                                                 : ppsch_pkg::PriW'($urandom_range(0, 255));
        send_item(item);
      end else if (slot_count >= MAX_PROCESSES && $urandom_range(0, 99) < 5) begin
        item        = ppsch_pkg::in_item_t'(InBits'({$urandom, $urandom}));
        item.action = ppsch_pkg::ActAdd;
        if ($urandom_range(0, 3) == 0) item.service_len = '0;
        send_item(item);
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_data_i     <= '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    slot_count    = 0;
    sched_time    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_priority_pick();
    test_late_add();
    test_extreme_fields();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(26, 26);

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[priority_preemptive_scheduler] OK");
    end else begin
      $display("[priority_preemptive_scheduler] ERROR");
    end
    $finish;
  end

endmodule
